/* rtl/rrqs_pkg.sv */
// Package for the round-robin queue scheduler: sizes, opcode and status codes,
// sequencer states and the result record passed between the sequencer and the output stage.
// No dependencies.
package rrqs_pkg;

    localparam int MAX_QUEUES = 64;
    localparam int SLOT_AW    = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int CNT_W      = $clog2(MAX_QUEUES + 1);
    localparam int ID_W       = 6;
    localparam int MASK_W     = 64;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DEL,
        SEQ_NXT,
        SEQ_FIN
    } seq_state_t;

    typedef struct packed {
        logic             grant_valid;
        logic [ID_W-1:0]  grant_id;
        logic [ST_W-1:0]  status;
    } result_t;

endpackage

/* rtl/rrqs_if.sv */
// Channel interfaces of the round-robin queue scheduler: request and response.
// Depends on rrqs_pkg for field widths.
interface rrqs_req_if import rrqs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ID_W-1:0]   queue_id;
    logic [MASK_W-1:0] nonempty_mask;

    modport source (output valid, output opcode, output queue_id, output nonempty_mask,
                    input ready);
    modport sink   (input valid, input opcode, input queue_id, input nonempty_mask,
                    output ready);
endinterface

interface rrqs_rsp_if import rrqs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             grant_valid;
    logic [ID_W-1:0]  grant_id;
    logic [ST_W-1:0]  status;

    modport source (output valid, output grant_valid, output grant_id, output status,
                    input ready);
    modport sink   (input valid, input grant_valid, input grant_id, input status,
                    output ready);
endinterface

/* rtl/rrqs_slot_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module rrqs_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/rrqs_seq.sv */
// Sequencer of the round-robin queue scheduler: holds the list length and the position,
// and walks the slot RAM one entry per cycle for delete and next. Depends on rrqs_pkg, rrqs_if.
module rrqs_seq import rrqs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    rrqs_req_if.sink           req,
    output result_t            res,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               ram_wr_en,
    output logic [SLOT_AW-1:0] ram_wr_addr,
    output logic [ID_W-1:0]    ram_wr_data,
    output logic [SLOT_AW-1:0] ram_rd_addr,
    input  logic [ID_W-1:0]    ram_rd_data
);

    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rr_reg, rr_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [SLOT_AW-1:0] rd_addr_reg, rd_addr_next;
    logic [SLOT_AW-1:0] data_addr_reg, data_addr_next;
    logic               found_reg, found_next;
    logic [ID_W-1:0]    qid_reg, qid_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    result_t            res_reg, res_next;
    logic [SLOT_AW-1:0] start_pos;

    // Slot index plus one, wrapped to zero at the list length.
    function automatic logic [SLOT_AW-1:0] wrap_inc(input logic [SLOT_AW-1:0] a,
                                                    input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] s;
        s = CNT_W'(a) + CNT_W'(1);
        if (s >= cnt)
        begin
            return '0;
        end
        return SLOT_AW'(s);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            count_reg     <= '0;
            rr_reg        <= '0;
            step_reg      <= '0;
            rd_addr_reg   <= '0;
            data_addr_reg <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rr_reg        <= rr_next;
            step_reg      <= step_next;
            rd_addr_reg   <= rd_addr_next;
            data_addr_reg <= data_addr_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qid_reg  <= qid_next;
        mask_reg <= mask_next;
        res_reg  <= res_next;
    end

    assign start_pos = (rr_reg >= count_reg) ? '0 : SLOT_AW'(rr_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rr_next        = rr_reg;
        step_next      = step_reg;
        rd_addr_next   = rd_addr_reg;
        data_addr_next = data_addr_reg;
        found_next     = found_reg;
        qid_next       = qid_reg;
        mask_next      = mask_reg;
        res_next       = res_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = ram_rd_data;
        ram_rd_addr    = rd_addr_reg;
        res_valid      = 1'b0;
        req.ready      = 1'b0;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    qid_next   = req.queue_id;
                    mask_next  = req.nonempty_mask;
                    res_next   = '0;
                    found_next = 1'b0;
                    step_next  = '0;
                    state_next = SEQ_FIN;
                    unique case (req.opcode)
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_QUEUES))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = SLOT_AW'(count_reg);
                                ram_wr_data = req.queue_id;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_rd_addr  = '0;
                                rd_addr_next = wrap_inc('0, count_reg);
                                state_next   = SEQ_DEL;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (count_reg != '0)
                            begin
                                // An out-of-range position is stored as zero even without a grant.
                                rr_next        = CNT_W'(start_pos);
                                ram_rd_addr    = start_pos;
                                rd_addr_next   = wrap_inc(start_pos, count_reg);
                                data_addr_next = start_pos;
                                state_next     = SEQ_NXT;
                            end
                        end
                        default:
                        begin
                            state_next = SEQ_FIN;
                        end
                    endcase
                end
            end

            SEQ_DEL:
            begin
                // Read data belongs to slot step_reg; once the id is found each entry
                // moves down by one, writing behind the read pointer.
                rd_addr_next = wrap_inc(rd_addr_reg, count_reg);
                if (found_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = SLOT_AW'(step_reg - CNT_W'(1));
                    ram_wr_data = ram_rd_data;
                end
                else if (ram_rd_data == qid_reg)
                begin
                    found_next = 1'b1;
                end
                if (step_reg == count_reg - CNT_W'(1))
                begin
                    if (found_reg || (ram_rd_data == qid_reg))
                    begin
                        count_next = count_reg - CNT_W'(1);
                        rr_next    = '0;
                    end
                    else
                    begin
                        res_next.status = ST_NOT_FOUND;
                    end
                    state_next = SEQ_FIN;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end

            SEQ_NXT:
            begin
                rd_addr_next   = wrap_inc(rd_addr_reg, count_reg);
                data_addr_next = wrap_inc(data_addr_reg, count_reg);
                if (mask_reg[ram_rd_data])
                begin
                    res_next.grant_valid = 1'b1;
                    res_next.grant_id    = ram_rd_data;
                    rr_next              = CNT_W'(wrap_inc(data_addr_reg, count_reg));
                    state_next           = SEQ_FIN;
                end
                else if (step_reg == count_reg - CNT_W'(1))
                begin
                    state_next = SEQ_FIN;
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end

            SEQ_FIN:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

/* rtl/rrqs_out_stage.sv */
// Output register of the round-robin queue scheduler: holds one result beat for the
// response channel. Depends on rrqs_pkg, rrqs_if.
module rrqs_out_stage import rrqs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  result_t   res,
    input  logic      res_valid,
    output logic      res_ready,
    rrqs_rsp_if.source rsp
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    assign res_ready = !valid_reg || rsp.ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.grant_valid = data_reg.grant_valid;
    assign rsp.grant_id    = data_reg.grant_id;
    assign rsp.status      = data_reg.status;

endmodule

/* rtl/round_robin_queue_scheduler.sv */
// Top level of the round-robin queue scheduler.
// Depends on rrqs_pkg, rrqs_if, rrqs_slot_ram, rrqs_seq and rrqs_out_stage.
//
// Requests arrive on req (opcode, queue_id, nonempty_mask) and each one produces
// exactly one response beat on rsp (grant_valid, grant_id, status). Add appends an
// id to the list, delete removes the first matching id and closes the gap, next
// scans the list from the round-robin position and grants the first queue whose
// mask bit is set.
// The list lives in a 64-entry slot RAM with registered read data; delete and
// next walk it one slot per cycle. One request is in work at a time, and the walk
// of the slot RAM sets the rate; the next request is accepted only once the
// result of the last one has gone to the output register.
// After reset the list is empty and the position is zero; no clearing pass is
// needed. A stalled receiver holds the response in the output register; the next
// request is still accepted, and its result waits in the sequencer until the
// register frees.
module round_robin_queue_scheduler import rrqs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    rrqs_req_if.sink   req,
    rrqs_rsp_if.source rsp
);

    result_t            res;
    logic               res_valid;
    logic               res_ready;
    logic               ram_wr_en;
    logic [SLOT_AW-1:0] ram_wr_addr;
    logic [ID_W-1:0]    ram_wr_data;
    logic [SLOT_AW-1:0] ram_rd_addr;
    logic [ID_W-1:0]    ram_rd_data;

    rrqs_slot_ram #(
        .DEPTH (MAX_QUEUES),
        .AW    (SLOT_AW),
        .DW    (ID_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rrqs_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    rrqs_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .rsp       (rsp)
    );

endmodule

/* rtl/rrqs_checker.sv */
// Port-level checks for the round-robin queue scheduler, bound to the top level.
// Depends on rrqs_pkg and round_robin_queue_scheduler.
module rrqs_checker import rrqs_pkg::*; (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input logic            rsp_grant_valid,
    input logic [ID_W-1:0] rsp_grant_id,
    input logic [ST_W-1:0] rsp_status
);

    // A response beat that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat withdrawn while stalled");

    // Only one request is in work, so acceptance closes the request channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_grant_valid |-> rsp_grant_id == '0)
        else $error("grant id not zero without a grant");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_grant_valid |-> rsp_status == ST_OK)
        else $error("grant reported with an error status");

endmodule

bind round_robin_queue_scheduler rrqs_checker u_rrqs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_grant_valid (rsp.grant_valid),
    .rsp_grant_id    (rsp.grant_id),
    .rsp_status      (rsp.status)
);

/* test/round_robin_queue_scheduler_test.sv */
`timescale 1ns / 100ps
// Testbench for round_robin_queue_scheduler: add, delete and next requests go in on the request
// channel; each response beat is checked against a queue-list predictor or, for typed rows,
// against the row's expected result. Depends on rrqs_pkg, rrqs_if and the scheduler RTL.
module round_robin_queue_scheduler_test;
    import rrqs_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 800;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   qid;
        logic [MASK_W-1:0] mask;
        logic              typed;
        result_t           exp;
    } stim_row_t;

    logic clk;
    logic rst_n;

    rrqs_req_if req_ch ();
    rrqs_rsp_if rsp_ch ();

    round_robin_queue_scheduler u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted state of the scheduler.
    logic [ID_W-1:0] list_ids [MAX_QUEUES];
    int              list_len = 0;
    int              rr_pos = 0;

    result_t   pending_results [$];
    stim_row_t directed_rows [$];
    int        error_count = 0;
    bit        steady = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic result_t apply_request(logic [OP_W-1:0] op, logic [ID_W-1:0] qid,
                                              logic [MASK_W-1:0] mask);
        result_t         r;
        int              at;
        int              pos;
        int              i;
        logic [ID_W-1:0] id;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD:
            begin
                if (list_len >= MAX_QUEUES)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    list_ids[list_len] = qid;
                    list_len++;
                end
            end
            OP_DEL:
            begin
                at = -1;
                for (i = 0; i < list_len; i++)
                begin
                    if (at < 0 && list_ids[i] == qid)
                        at = i;
                end
                if (at < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    for (i = at; i + 1 < list_len; i++)
                        list_ids[i] = list_ids[i + 1];
                    list_len--;
                    rr_pos = 0;
                end
            end
            OP_NEXT:
            begin
                if (list_len != 0)
                begin
                    pos = (rr_pos >= list_len) ? 0 : rr_pos;
                    for (i = 0; i < list_len; i++)
                    begin
                        id = list_ids[pos];
                        pos++;
                        if (pos >= list_len)
                            pos = 0;
                        if (mask[id])
                        begin
                            r.grant_valid = 1'b1;
                            r.grant_id = id;
                            break;
                        end
                    end
                    rr_pos = pos;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic stim_row_t make_row(logic [OP_W-1:0] op, logic [ID_W-1:0] qid,
                                           logic [MASK_W-1:0] mask, logic typed,
                                           logic gv, logic [ID_W-1:0] gid,
                                           logic [ST_W-1:0] st);
        stim_row_t r;
        r.op = op;
        r.qid = qid;
        r.mask = mask;
        r.typed = typed;
        r.exp.grant_valid = gv;
        r.exp.grant_id = gid;
        r.exp.status = st;
        return r;
    endfunction

    // Masks range from empty and full to single bits and sparse patterns, so that
    // scans run long as well as short.
    function automatic logic [MASK_W-1:0] pick_mask();
        logic [MASK_W-1:0] m;
        int                mode;
        mode = $urandom_range(19);
        m = {$urandom(), $urandom()};
        if (mode == 0)
            m = '0;
        else if (mode == 1)
            m = '1;
        else if (mode < 6)
        begin
            m = '0;
            m[$urandom_range(MASK_W - 1)] = 1'b1;
        end
        else if (mode < 11)
            m = m & {$urandom(), $urandom()} & {$urandom(), $urandom()};
        return m;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is accepted.
    task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] qid,
                                logic [MASK_W-1:0] mask, logic typed, result_t exp);
        result_t predicted;
        while (!steady && $urandom_range(99) < 7)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.queue_id <= qid;
        req_ch.nonempty_mask <= mask;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_request(op, qid, mask);
        pending_results.push_back(typed ? exp : predicted);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 7);
    end

    always @(posedge clk)
    begin : check_beat
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_error("response beat with no request outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.grant_valid !== want.grant_valid)
                    report_error($sformatf("grant_valid: expected %0d, got %0d",
                                           want.grant_valid, rsp_ch.grant_valid));
                if (rsp_ch.grant_id !== want.grant_id)
                    report_error($sformatf("grant_id: expected %0d, got %0d",
                                           want.grant_id, rsp_ch.grant_id));
                if (rsp_ch.status !== want.status)
                    report_error($sformatf("status: expected %0d, got %0d",
                                           want.status, rsp_ch.status));
            end
        end
    end

    initial
    begin : stimulus
        int              sent;
        int              phase;
        int              phase_len;
        int              pick;
        int              k;
        int              add_w;
        int              del_w;
        int              miss_w;
        bit              first;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] qid;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_ADD;
        req_ch.queue_id = '0;
        req_ch.nonempty_mask = '0;
        rsp_ch.ready = 1'b0;

        // Empty list, missing delete, unused opcode, then a short list with a duplicate.
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, '1, 1'b1, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_DEL, 6'd42, '0, 1'b1, 1'b0, 6'd0, ST_NOT_FOUND));
        directed_rows.push_back(make_row(OP_NONE, 6'd63, '1, 1'b1, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_ADD, 6'd0, '0, 1'b1, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_ADD, 6'd63, '0, 1'b1, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_ADD, 6'd63, '0, 1'b1, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_ADD, 6'd21, '1, 1'b1, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, '0, 1'b1, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd63, '1, 1'b1, 1'b1, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, 64'h8000_0000_0000_0000, 1'b0,
                                         1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, 64'h8000_0000_0000_0000, 1'b0,
                                         1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, 64'h0000_0000_0020_0000, 1'b0,
                                         1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, 64'h0000_0000_0000_0001, 1'b0,
                                         1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_DEL, 6'd63, '0, 1'b0, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_DEL, 6'd7, '1, 1'b1, 1'b0, 6'd0, ST_NOT_FOUND));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, '1, 1'b0, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, 64'h5555_5555_5555_5555, 1'b0,
                                         1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
                                         1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_DEL, 6'd0, '0, 1'b0, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_DEL, 6'd63, '0, 1'b0, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_DEL, 6'd21, '0, 1'b0, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_NEXT, 6'd0, '1, 1'b0, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_ADD, 6'h2A, '0, 1'b0, 1'b0, 6'd0, ST_OK));
        directed_rows.push_back(make_row(OP_ADD, 6'h15, '0, 1'b0, 1'b0, 6'd0, ST_OK));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].qid, directed_rows[i].mask,
                         directed_rows[i].typed, directed_rows[i].exp);

        // Random part in phases: filling the list up to and past full, draining it
        // by deleting ids that are present, and a mixture of both.
        sent = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            phase = first ? 0 : $urandom_range(2);
            first = 1'b0;
            phase_len = (phase == 0) ? $urandom_range(130, 220) : $urandom_range(30, 120);
            case (phase)
                0:       begin add_w = 55; del_w = 0;  miss_w = 3;  end
                1:       begin add_w = 0;  del_w = 45; miss_w = 10; end
                default: begin add_w = 30; del_w = 25; miss_w = 5;  end
            endcase
            for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                steady = (sent >= 300 && sent < 420);
                pick = $urandom_range(99);
                qid = ID_W'($urandom_range(63));
                if (pick < add_w)
                begin
                    op = OP_ADD;
                end
                else if (pick < add_w + del_w)
                begin
                    op = OP_DEL;
                    if (list_len > 0)
                        qid = list_ids[$urandom_range(list_len - 1)];
                end
                else if (pick < add_w + del_w + miss_w)
                    op = OP_DEL;
                else if (pick < 95)
                    op = OP_NEXT;
                else
                    op = OP_NONE;
                send_request(op, qid, pick_mask(), 1'b0, '0);
                if (op != OP_NONE)
                    sent++;
            end
        end
        steady = 1'b0;
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* round_robin_queue_scheduler.f */
rtl/rrqs_pkg.sv
rtl/rrqs_if.sv
rtl/rrqs_slot_ram.sv
rtl/rrqs_seq.sv
rtl/rrqs_out_stage.sv
rtl/round_robin_queue_scheduler.sv
rtl/rrqs_checker.sv
test/round_robin_queue_scheduler_test.sv
